// ===== hw/rtl/agc_pkg.sv =====
// ----------------------------------------------------------------------------
// agc_pkg: shared types and constants for the annulus gray average core
// Widths, register codes and controller command/status bundles.
// ----------------------------------------------------------------------------
package agc_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 7;
  localparam int RADIUS_MAX  = 127;
  localparam int FRAC_BITS   = 8;
  localparam int GRAY_BITS   = 8;
  localparam int SUM_BITS    = 24;
  localparam int COUNT_BITS  = 16;
  localparam int MEAN_BITS   = 16;

  localparam int SQ_BITS       = 2 * COORD_BITS;
  localparam int D2_BITS       = SQ_BITS + 1;
  localparam int RSQ_BITS      = 2 * RADIUS_BITS;
  localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
  localparam int STEP_BITS     = $clog2(DIVIDEND_BITS);

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = COORD_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS_A = 2'd2,
    REG_RADIUS_B = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_DIV_LAUNCH,
    S_DIVIDE,
    S_PUBLISH
  } ctrl_state_t;

  typedef struct packed {
    logic load_pixel;
    logic square;
    logic accumulate;
    logic div_start;
    logic out_load;
  } agc_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
  } agc_sts_t;

  function automatic logic [RADIUS_BITS-1:0] clamp_radius(input logic [RADIUS_BITS-1:0] r);
    if (int'(r) > RADIUS_MAX) begin
      return RADIUS_BITS'(RADIUS_MAX);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/agc_ifs.sv =====
// ----------------------------------------------------------------------------
// agc_ifs: channel interfaces of the annulus gray average core
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface agc_pixel_if;
  import agc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_column;
  logic [COORD_BITS-1:0] pixel_row;
  logic [GRAY_BITS-1:0]  gray_level;
  logic                  frame_end;

  modport source (output valid, pixel_column, pixel_row, gray_level, frame_end,
                  input ready);
  modport sink (input valid, pixel_column, pixel_row, gray_level, frame_end,
                output ready);
endinterface

interface agc_result_if;
  import agc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [MEAN_BITS-1:0]  mean_q8;
  logic                  ring_empty;
  logic [COUNT_BITS-1:0] ring_pixels;

  modport source (output valid, mean_q8, ring_empty, ring_pixels, input ready);
  modport sink (input valid, mean_q8, ring_empty, ring_pixels, output ready);
endinterface

interface agc_cfg_if;
  import agc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/agc_ctrl.sv =====
// ----------------------------------------------------------------------------
// agc_ctrl: sequencing state machine
// Steps each pixel through square and accumulate, runs the divide at frame
// end and owns the output valid flag.
// ----------------------------------------------------------------------------
module agc_ctrl import agc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output agc_cmd_t cmd,
  input  agc_sts_t sts
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:       if (in_valid) state_nxt = S_SQUARE;
      S_SQUARE:     state_nxt = S_ACCUM;
      S_ACCUM:      state_nxt = sts.last ? S_DIV_LAUNCH : S_IDLE;
      S_DIV_LAUNCH: state_nxt = S_DIVIDE;
      S_DIVIDE:     if (sts.div_done) state_nxt = S_PUBLISH;
      S_PUBLISH:    if (slot_free) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    cmd.load_pixel = (state_r == S_IDLE) && in_valid;
    cmd.square     = (state_r == S_SQUARE);
    cmd.accumulate = (state_r == S_ACCUM);
    cmd.div_start  = (state_r == S_DIV_LAUNCH);
    cmd.out_load   = (state_r == S_PUBLISH) && slot_free;
    in_ready       = (state_r == S_IDLE);
    out_valid_nxt  = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_publish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("publish did not raise out_valid");

  a_plain_pixel_returns: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACCUM && !sts.last |=> state_r == S_IDLE)
    else $error("non-final pixel did not return to idle");

  a_done_only_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIVIDE)
    else $error("divide done outside divide state");

endmodule

// ===== hw/rtl/agc_divider.sv =====
// ----------------------------------------------------------------------------
// agc_divider: iterative restoring divider
// One quotient bit per cycle; a one-cycle done pulse comes with the last bit.
// ----------------------------------------------------------------------------
module agc_divider import agc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [COUNT_BITS-1:0]    divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [STEP_BITS-1:0]     step_r, step_nxt;
  logic [DIVIDEND_BITS-1:0] quo_r, quo_nxt;
  logic [COUNT_BITS-1:0]    rem_r, rem_nxt;
  logic [COUNT_BITS-1:0]    dvs_r, dvs_nxt;
  logic [COUNT_BITS:0]      rem_shift;
  logic                     fits;

  assign rem_shift = {rem_r, quo_r[DIVIDEND_BITS-1]};
  assign fits      = rem_shift >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[DIVIDEND_BITS-2:0], fits};
      rem_nxt  = fits ? COUNT_BITS'(rem_shift - {1'b0, dvs_r}) : rem_shift[COUNT_BITS-1:0];
      step_nxt = step_r + STEP_BITS'(1);
      if (step_r == STEP_BITS'(DIVIDEND_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/agc_datapath.sv =====
// ----------------------------------------------------------------------------
// agc_datapath: ring test, accumulators, divide and result register
// Holds the configuration registers and the running sum and count.
// ----------------------------------------------------------------------------
module agc_datapath import agc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic [COORD_BITS-1:0]    in_column,
  input  logic [COORD_BITS-1:0]    in_row,
  input  logic [GRAY_BITS-1:0]     in_gray,
  input  logic                     in_last,
  input  agc_cmd_t                 cmd,
  output agc_sts_t                 sts,
  output logic [MEAN_BITS-1:0]     mean_q8,
  output logic                     ring_empty,
  output logic [COUNT_BITS-1:0]    ring_pixels
);

  // configuration
  logic [COORD_BITS-1:0]  center_x_r, center_y_r;
  logic [RADIUS_BITS-1:0] radius_a_r, radius_b_r;

  // pixel capture and square stage
  logic [COORD_BITS-1:0]  col_r, row_r;
  logic [GRAY_BITS-1:0]   gray_r;
  logic                   last_r;
  logic [SQ_BITS-1:0]     dx_sq_r, dy_sq_r;
  logic [RSQ_BITS-1:0]    inner_sq_r, outer_sq_r;

  // accumulators and frame snapshot
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [SUM_BITS-1:0]    frame_sum_r;
  logic [COUNT_BITS-1:0]  frame_count_r;

  logic [MEAN_BITS-1:0]   mean_r;
  logic                   empty_r;
  logic [COUNT_BITS-1:0]  pixels_r;

  logic [COORD_BITS-1:0]    dx, dy;
  logic [RADIUS_BITS-1:0]   ra, rb, r_in, r_out;
  logic [D2_BITS-1:0]       d2;
  logic                     hit;
  logic [SUM_BITS:0]        sum_wide;
  logic                     div_done;
  logic [DIVIDEND_BITS-1:0] quotient;
  logic [MEAN_BITS-1:0]     mean_sat;
  logic                     frame_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_a_r <= '0;
      radius_b_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: center_x_r <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_Y: center_y_r <= cfg_data[COORD_BITS-1:0];
        REG_RADIUS_A: radius_a_r <= cfg_data[RADIUS_BITS-1:0];
        REG_RADIUS_B: radius_b_r <= cfg_data[RADIUS_BITS-1:0];
      endcase
    end
  end

  // square stage
  assign dx    = (col_r >= center_x_r) ? col_r - center_x_r : center_x_r - col_r;
  assign dy    = (row_r >= center_y_r) ? row_r - center_y_r : center_y_r - row_r;
  assign ra    = clamp_radius(radius_a_r);
  assign rb    = clamp_radius(radius_b_r);
  assign r_in  = (ra < rb) ? ra : rb;
  assign r_out = (ra < rb) ? rb : ra;

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      col_r  <= in_column;
      row_r  <= in_row;
      gray_r <= in_gray;
      last_r <= in_last;
    end
    if (cmd.square) begin
      dx_sq_r    <= SQ_BITS'(dx) * SQ_BITS'(dx);
      dy_sq_r    <= SQ_BITS'(dy) * SQ_BITS'(dy);
      inner_sq_r <= RSQ_BITS'(r_in) * RSQ_BITS'(r_in);
      outer_sq_r <= RSQ_BITS'(r_out) * RSQ_BITS'(r_out);
    end
  end

  // ring test and saturating accumulate
  assign d2       = {1'b0, dx_sq_r} + {1'b0, dy_sq_r};
  assign hit      = (d2 >= D2_BITS'(inner_sq_r)) && (d2 < D2_BITS'(outer_sq_r));
  assign sum_wide = {1'b0, sum_r} + (SUM_BITS + 1)'(gray_r);

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (hit) begin
      sum_nxt   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
      count_nxt = (&count_r) ? count_r : count_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (cmd.accumulate) begin
      if (last_r) begin
        sum_r   <= '0;
        count_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accumulate && last_r) begin
      frame_sum_r   <= sum_nxt;
      frame_count_r <= count_nxt;
    end
  end

  agc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (DIVIDEND_BITS'(frame_sum_r) << FRAC_BITS),
    .divisor  (frame_count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign frame_empty = (frame_count_r == '0);
  assign mean_sat    = (|quotient[DIVIDEND_BITS-1:MEAN_BITS]) ? '1 : quotient[MEAN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_r   <= frame_empty ? '0 : mean_sat;
      empty_r  <= frame_empty;
      pixels_r <= frame_count_r;
    end
  end

  assign sts.last     = last_r;
  assign sts.div_done = div_done;
  assign mean_q8      = mean_r;
  assign ring_empty   = empty_r;
  assign ring_pixels  = pixels_r;

  a_clear_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accumulate && last_r |=> sum_r == '0 && count_r == '0)
    else $error("accumulators not cleared after frame end");

  a_snapshot_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accumulate && last_r |=> frame_count_r == $past(count_nxt))
    else $error("frame count snapshot mismatch");

  a_empty_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> sum_r == '0)
    else $error("sum nonzero with zero count");

endmodule

// ===== hw/rtl/annulus_gray_average_core.sv =====
// ----------------------------------------------------------------------------
// annulus_gray_average_core: mean gray level inside a ring
// Tests each pixel against the ring between two radii around a configured
// center, accumulates gray sum and count, and at frame end emits the mean
// in 8.8 fixed point with the pixel count and an empty flag.
// ----------------------------------------------------------------------------
//
//  channel     dir  handshake          payload
//  in_chan     in   valid/ready        pixel_column, pixel_row, gray_level,
//                                      frame_end
//  out_chan    out  valid/ready        mean_q8, ring_empty, ring_pixels
//  cfg_chan    in   valid/ready (=1)   index (0..3), data
//
//  Each pixel is handled in order: capture, square (two 12x12 and two 7x7
//  multipliers), then ring compare and accumulate; the next pixel is taken
//  only once it is through. A frame_end pixel then adds launch, 32 steps of
//  the restoring divider (one quotient bit per cycle), done flag, publish.
//  Reset is synchronous: clears config, accumulators and the controller.
//  The output register holds a result while out_chan stalls; pixels of the
//  next frame are still taken, a further frame end waits in publish.
//
module annulus_gray_average_core import agc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  agc_pixel_if.sink    in_chan,
  agc_result_if.source out_chan,
  agc_cfg_if.sink      cfg_chan
);

  agc_cmd_t cmd;
  agc_sts_t sts;

  // config writes are always taken
  assign cfg_chan.ready = 1'b1;

  agc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  agc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_chan.valid),
    .cfg_index   (cfg_chan.index),
    .cfg_data    (cfg_chan.data),
    .in_column   (in_chan.pixel_column),
    .in_row      (in_chan.pixel_row),
    .in_gray     (in_chan.gray_level),
    .in_last     (in_chan.frame_end),
    .cmd         (cmd),
    .sts         (sts),
    .mean_q8     (out_chan.mean_q8),
    .ring_empty  (out_chan.ring_empty),
    .ring_pixels (out_chan.ring_pixels)
  );

endmodule
